/* rtl/fit_policy_block_allocator_macros.svh */
// assertion macros used by the checker file
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define FPBA_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication, quiet while reset is high
`define FPBA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

/* rtl/fpba_pkg.sv */
// shared types and constants of the fit-policy block allocator
`default_nettype none
package fpba_pkg;

   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int ADDRESS_BITS_DEF = 20;

   localparam int HEADER_BYTES = 32;
   localparam int GRAIN_BYTES  = 8;
   localparam int PAGE_SHIFT   = 12;
   localparam int MAX_PAGES    = 256;

   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_BEST  = 2'd1;
   localparam logic [1:0] MODE_WORST = 2'd2;
   localparam logic [1:0] MODE_FIRST = 2'd3;

   localparam logic [1:0] FIT_MODE_RESET = MODE_BEST;
   localparam logic [8:0] REGION_RESET   = 9'd16;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic REG_FIT_MODE = 1'b0;
   localparam logic REG_REGION   = 1'b1;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NO_FIT    = 3'd1;
   localparam logic [2:0] STATUS_ZERO      = 3'd2;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STATUS_NO_MODE   = 3'd4;

   typedef enum logic [2:0] {
      ST_FORM,
      ST_IDLE,
      ST_SCAN,
      ST_ADEC,
      ST_FNEXT,
      ST_MOVE,
      ST_SPLIT,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

/* rtl/fit_policy_block_allocator.sv */
// fit-policy block allocator: block table in a memory, one sequencer over it
//
//   channel   ports                                          handshake
//   request   req_kind, req_request_bytes, req_free_address  start high, busy low
//   result    rsp_address, rsp_status                        rsp_valid, one cycle
//   config    psel penable pwrite paddr pwdata prdata        APB, pready tied high
//
// an item runs a table scan (one entry a cycle through the memory read port),
// followed by an entry shift when a split or merge moves entries
// reset and a region_pages write re-form the table as one free block; after reset
// the block stays busy while entry 0 is written
// zero-size and no-mode allocations skip the table scan and go straight to the result
// results cannot be stalled: rsp_valid marks one cycle per item
`default_nettype none
module fit_policy_block_allocator #(
   parameter int MAX_BLOCKS   = fpba_pkg::MAX_BLOCKS_DEF,
   parameter int ADDRESS_BITS = fpba_pkg::ADDRESS_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic                    req_kind,
   input  wire logic [ADDRESS_BITS-1:0] req_request_bytes,
   input  wire logic [ADDRESS_BITS-1:0] req_free_address,
   output logic                         rsp_valid,
   output logic [ADDRESS_BITS-1:0]      rsp_address,
   output logic [2:0]                   rsp_status,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [2:0]              paddr,
   input  wire logic [31:0]             pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   localparam int AW = ADDRESS_BITS;
   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int BW = (AW + 1 > 21) ? AW + 1 : 21;
   localparam logic [BW-1:0] LIMIT = BW'(1) << AW;
   localparam logic [AW:0] HDR   = (AW+1)'(fpba_pkg::HEADER_BYTES);
   localparam logic [AW:0] RND   = (AW+1)'(fpba_pkg::GRAIN_BYTES - 1);
   localparam logic [AW:0] SPLIT_MIN =
      (AW+1)'(fpba_pkg::HEADER_BYTES + fpba_pkg::GRAIN_BYTES);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

   function automatic logic [AW-1:0] region_payload(input logic [8:0] pages);
      logic [8:0]    p;
      logic [BW-1:0] bytes;
      p = pages;
      if (p == 9'd0) begin
         p = 9'd1;
      end else if (p > 9'(fpba_pkg::MAX_PAGES)) begin
         p = 9'(fpba_pkg::MAX_PAGES);
      end
      bytes = BW'(p) << fpba_pkg::PAGE_SHIFT;
      if (bytes > LIMIT) begin
         bytes = LIMIT;
      end
      return AW'(bytes - BW'(fpba_pkg::HEADER_BYTES));
   endfunction

   fpba_pkg::state_type state_ff, state_in;

   logic [1:0]    mode_ff, mode_in;
   logic [8:0]    pages_ff, pages_in;
   logic [CW-1:0] count_ff, count_in;

   logic [AW-1:0] mem_start [MAX_BLOCKS];
   logic [AW-1:0] mem_pay   [MAX_BLOCKS];
   logic          mem_free  [MAX_BLOCKS];
   logic [AW-1:0] rd_start_ff, rd_pay_ff;
   logic          rd_free_ff;
   logic          we;
   logic [IW-1:0] wa, ra;
   logic [AW-1:0] wd_start, wd_pay;
   logic          wd_free;

   logic          kind_ff, kind_in;
   logic [AW:0]   need_ff, need_in;
   logic [AW-1:0] faddr_ff, faddr_in;

   logic [CW-1:0] ptr_ff, ptr_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [IW-1:0] chk_idx_ff, chk_idx_in;

   logic          found_ff, found_in;
   logic [IW-1:0] pick_idx_ff, pick_idx_in;
   logic [AW-1:0] pick_start_ff, pick_start_in, pick_pay_ff, pick_pay_in;
   logic          hit_free_ff, hit_free_in;
   logic [AW-1:0] prev_start_ff, prev_start_in, prev_pay_ff, prev_pay_in;
   logic          prev_free_ff, prev_free_in;

   logic [CW-1:0] mv_src_ff, mv_src_in, mv_left_ff, mv_left_in;
   logic          mv_up_ff, mv_up_in;
   logic [1:0]    mv_d_ff, mv_d_in;
   logic          wr_pend_ff, wr_pend_in;
   logic [IW-1:0] wr_addr_ff, wr_addr_in;

   logic [AW-1:0] res_addr_ff, res_addr_in;
   logic [2:0]    res_status_ff, res_status_in;

   // decode shared by next-state and datapath
   logic          accept, csr_wr;
   logic          fits, better, take, match, scan_end;
   logic          split_ok, has_prev, nxt_ok, mg_prev, mg_next;
   logic [AW:0]   left_over, merged_pay;
   logic [1:0]    mg_d;
   logic [CW:0]   mg_src;

   assign accept = start && !busy;
   assign csr_wr = psel && penable && pwrite && pready;

   assign fits     = rd_free_ff && ({1'b0, rd_pay_ff} >= need_ff);
   assign better   = !found_ff
                     || (mode_ff == fpba_pkg::MODE_BEST  && rd_pay_ff < pick_pay_ff)
                     || (mode_ff == fpba_pkg::MODE_WORST && rd_pay_ff > pick_pay_ff);
   assign take     = chk_vld_ff && kind_ff == fpba_pkg::KIND_ALLOC && fits && better;
   assign match    = chk_vld_ff && kind_ff == fpba_pkg::KIND_FREE
                     && ({1'b0, rd_start_ff} + HDR) == {1'b0, faddr_ff};
   assign scan_end = !chk_vld_ff && ptr_ff >= count_ff;

   assign left_over = {1'b0, pick_pay_ff} - need_ff;
   assign split_ok  = left_over >= SPLIT_MIN && count_ff < CNT_MAX;

   assign has_prev = pick_idx_ff != IW'(0);
   assign nxt_ok   = (CW'(pick_idx_ff) + CW'(1)) < count_ff;
   assign mg_prev  = has_prev && prev_free_ff;
   assign mg_next  = nxt_ok && rd_free_ff;
   assign mg_d     = {1'b0, mg_prev} + {1'b0, mg_next};
   assign merged_pay = (mg_prev ? {1'b0, prev_pay_ff} + HDR + {1'b0, pick_pay_ff}
                                : {1'b0, pick_pay_ff})
                       + (mg_next ? HDR + {1'b0, rd_pay_ff} : (AW+1)'(0));
   // first entry to pull down after the merge
   assign mg_src   = (CW+1)'(pick_idx_ff) + (CW+1)'(1) + (CW+1)'(mg_next);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpba_pkg::ST_FORM: begin
            state_in = fpba_pkg::ST_IDLE;
         end
         fpba_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_kind == fpba_pkg::KIND_ALLOC
                   && (mode_ff == fpba_pkg::MODE_NONE || req_request_bytes == '0)) begin
                  state_in = fpba_pkg::ST_DONE;
               end else begin
                  state_in = fpba_pkg::ST_SCAN;
               end
            end
         end
         fpba_pkg::ST_SCAN: begin
            if (match) begin
               state_in = fpba_pkg::ST_FNEXT;
            end else if (take && mode_ff == fpba_pkg::MODE_FIRST) begin
               state_in = fpba_pkg::ST_ADEC;
            end else if (scan_end) begin
               state_in = (kind_ff == fpba_pkg::KIND_ALLOC) ? fpba_pkg::ST_ADEC
                                                            : fpba_pkg::ST_DONE;
            end
         end
         fpba_pkg::ST_ADEC: begin
            if (found_ff && split_ok) begin
               state_in = (count_ff - CW'(1) > CW'(pick_idx_ff)) ? fpba_pkg::ST_MOVE
                                                                : fpba_pkg::ST_SPLIT;
            end else begin
               state_in = fpba_pkg::ST_DONE;
            end
         end
         fpba_pkg::ST_FNEXT: begin
            if (!hit_free_ff && mg_d != 2'd0 && mg_src < (CW+1)'(count_ff)) begin
               state_in = fpba_pkg::ST_MOVE;
            end else begin
               state_in = fpba_pkg::ST_DONE;
            end
         end
         fpba_pkg::ST_MOVE: begin
            if (mv_left_ff == '0 && !wr_pend_ff) begin
               state_in = mv_up_ff ? fpba_pkg::ST_SPLIT : fpba_pkg::ST_DONE;
            end
         end
         fpba_pkg::ST_SPLIT: begin
            state_in = fpba_pkg::ST_DONE;
         end
         fpba_pkg::ST_DONE: begin
            state_in = fpba_pkg::ST_IDLE;
         end
         default: begin
            state_in = fpba_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory port control
   always_comb begin
      mode_in       = mode_ff;
      pages_in      = pages_ff;
      count_in      = count_ff;
      kind_in       = kind_ff;
      need_in       = need_ff;
      faddr_in      = faddr_ff;
      ptr_in        = ptr_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      found_in      = found_ff;
      pick_idx_in   = pick_idx_ff;
      pick_start_in = pick_start_ff;
      pick_pay_in   = pick_pay_ff;
      hit_free_in   = hit_free_ff;
      prev_start_in = prev_start_ff;
      prev_pay_in   = prev_pay_ff;
      prev_free_in  = prev_free_ff;
      mv_src_in     = mv_src_ff;
      mv_left_in    = mv_left_ff;
      mv_up_in      = mv_up_ff;
      mv_d_in       = mv_d_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = wr_addr_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      we       = 1'b0;
      wa       = '0;
      wd_start = '0;
      wd_pay   = '0;
      wd_free  = 1'b0;
      ra       = ptr_ff[IW-1:0];

      case (state_ff)
         fpba_pkg::ST_FORM: begin
            we       = 1'b1;
            wd_pay   = region_payload(pages_ff);
            wd_free  = 1'b1;
            count_in = CW'(1);
         end
         fpba_pkg::ST_IDLE: begin
            if (csr_wr) begin
               if (paddr[2] == fpba_pkg::REG_FIT_MODE) begin
                  mode_in = pwdata[1:0];
               end else begin
                  pages_in = pwdata[8:0];
                  we       = 1'b1;
                  wd_pay   = region_payload(pwdata[8:0]);
                  wd_free  = 1'b1;
                  count_in = CW'(1);
               end
            end
            if (accept) begin
               kind_in     = req_kind;
               need_in     = ({1'b0, req_request_bytes} + RND) & ~RND;
               faddr_in    = req_free_address;
               ptr_in      = '0;
               found_in    = 1'b0;
               res_addr_in = '0;
               if (req_kind == fpba_pkg::KIND_ALLOC) begin
                  if (mode_ff == fpba_pkg::MODE_NONE) begin
                     res_status_in = fpba_pkg::STATUS_NO_MODE;
                  end else if (req_request_bytes == '0) begin
                     res_status_in = fpba_pkg::STATUS_ZERO;
                  end
               end
            end
         end
         fpba_pkg::ST_SCAN: begin
            if (ptr_ff < count_ff) begin
               ptr_in     = ptr_ff + CW'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = ptr_ff[IW-1:0];
            end
            if (take || match) begin
               found_in      = 1'b1;
               pick_idx_in   = chk_idx_ff;
               pick_start_in = rd_start_ff;
               pick_pay_in   = rd_pay_ff;
               hit_free_in   = rd_free_ff;
            end
            if (chk_vld_ff && !match) begin
               prev_start_in = rd_start_ff;
               prev_pay_in   = rd_pay_ff;
               prev_free_in  = rd_free_ff;
            end
            if (scan_end && kind_ff == fpba_pkg::KIND_FREE) begin
               res_status_in = fpba_pkg::STATUS_NOT_FOUND;
            end
         end
         fpba_pkg::ST_ADEC: begin
            if (!found_ff) begin
               res_status_in = fpba_pkg::STATUS_NO_FIT;
            end else begin
               res_status_in = fpba_pkg::STATUS_OK;
               res_addr_in   = AW'({1'b0, pick_start_ff} + HDR);
               we       = 1'b1;
               wa       = pick_idx_ff;
               wd_start = pick_start_ff;
               wd_pay   = split_ok ? need_ff[AW-1:0] : pick_pay_ff;
               if (split_ok) begin
                  count_in   = count_ff + CW'(1);
                  mv_src_in  = count_ff - CW'(1);
                  mv_left_in = count_ff - CW'(1) - CW'(pick_idx_ff);
                  mv_up_in   = 1'b1;
                  mv_d_in    = 2'd1;
               end
            end
         end
         fpba_pkg::ST_FNEXT: begin
            res_status_in = fpba_pkg::STATUS_OK;
            if (!hit_free_ff) begin
               we       = 1'b1;
               wa       = mg_prev ? pick_idx_ff - IW'(1) : pick_idx_ff;
               wd_start = mg_prev ? prev_start_ff : pick_start_ff;
               wd_pay   = merged_pay[AW-1:0];
               wd_free  = 1'b1;
               count_in = count_ff - CW'(mg_d);
               mv_src_in  = mg_src[CW-1:0];
               mv_left_in = (mg_src < (CW+1)'(count_ff))
                            ? CW'((CW+1)'(count_ff) - mg_src) : '0;
               mv_up_in   = 1'b0;
               mv_d_in    = mg_d;
            end
         end
         fpba_pkg::ST_MOVE: begin
            ra = mv_src_ff[IW-1:0];
            if (mv_left_ff != '0) begin
               wr_pend_in = 1'b1;
               wr_addr_in = mv_up_ff ? IW'(mv_src_ff + CW'(1))
                                     : IW'(mv_src_ff - CW'(mv_d_ff));
               mv_src_in  = mv_up_ff ? mv_src_ff - CW'(1) : mv_src_ff + CW'(1);
               mv_left_in = mv_left_ff - CW'(1);
            end
            if (wr_pend_ff) begin
               we       = 1'b1;
               wa       = wr_addr_ff;
               wd_start = rd_start_ff;
               wd_pay   = rd_pay_ff;
               wd_free  = rd_free_ff;
            end
         end
         fpba_pkg::ST_SPLIT: begin
            we       = 1'b1;
            wa       = pick_idx_ff + IW'(1);
            wd_start = AW'({1'b0, pick_start_ff} + HDR + need_ff);
            wd_pay   = AW'(left_over - HDR);
            wd_free  = 1'b1;
         end
         fpba_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      busy        = state_ff != fpba_pkg::ST_IDLE;
      rsp_valid   = state_ff == fpba_pkg::ST_DONE;
      rsp_address = res_addr_ff;
      rsp_status  = res_status_ff;
      pready      = 1'b1;
      prdata      = (paddr[2] == fpba_pkg::REG_FIT_MODE) ? {30'd0, mode_ff}
                                                         : {23'd0, pages_ff};
   end

   // block table
   always_ff @(posedge clock) begin
      if (we) begin
         mem_start[wa] <= wd_start;
         mem_pay[wa]   <= wd_pay;
         mem_free[wa]  <= wd_free;
      end
      rd_start_ff <= mem_start[ra];
      rd_pay_ff   <= mem_pay[ra];
      rd_free_ff  <= mem_free[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fpba_pkg::ST_FORM;
         mode_ff       <= fpba_pkg::FIT_MODE_RESET;
         pages_ff      <= fpba_pkg::REGION_RESET;
         count_ff      <= CW'(1);
         chk_vld_ff    <= 1'b0;
         wr_pend_ff    <= 1'b0;
         mv_left_ff    <= '0;
         found_ff      <= 1'b0;
         ptr_ff        <= '0;
         res_status_ff <= fpba_pkg::STATUS_OK;
         res_addr_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         pages_ff      <= pages_in;
         count_ff      <= count_in;
         chk_vld_ff    <= chk_vld_in;
         wr_pend_ff    <= wr_pend_in;
         mv_left_ff    <= mv_left_in;
         found_ff      <= found_in;
         ptr_ff        <= ptr_in;
         res_status_ff <= res_status_in;
         res_addr_ff   <= res_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      need_ff       <= need_in;
      faddr_ff      <= faddr_in;
      chk_idx_ff    <= chk_idx_in;
      pick_idx_ff   <= pick_idx_in;
      pick_start_ff <= pick_start_in;
      pick_pay_ff   <= pick_pay_in;
      hit_free_ff   <= hit_free_in;
      prev_start_ff <= prev_start_in;
      prev_pay_ff   <= prev_pay_in;
      prev_free_ff  <= prev_free_in;
      mv_src_ff     <= mv_src_in;
      mv_up_ff      <= mv_up_in;
      mv_d_ff       <= mv_d_in;
      wr_addr_ff    <= wr_addr_in;
   end

endmodule
`default_nettype wire

/* rtl/fpba_checker.sv */
// port-level checks of the fit-policy block allocator
`default_nettype none
`include "fit_policy_block_allocator_macros.svh"
module fpba_checker #(
   parameter int ADDRESS_BITS = fpba_pkg::ADDRESS_BITS_DEF
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    start,
   input wire logic                    busy,
   input wire logic                    rsp_valid,
   input wire logic [ADDRESS_BITS-1:0] rsp_address,
   input wire logic [2:0]              rsp_status
);

   // an accepted item keeps the block busy until its result
   `FPBA_ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy || rsp_valid)
   // one result per item, never two in a row
   `FPBA_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   // failed allocations and frees report offset zero
   `FPBA_ASSERT_IMPL(a_fail_zero, clock, reset,
                     rsp_valid && rsp_status != fpba_pkg::STATUS_OK, rsp_address == '0)
   `FPBA_ASSERT_IMPL(a_status_code, clock, reset, rsp_valid,
                     rsp_status <= fpba_pkg::STATUS_NO_MODE)

endmodule

bind fit_policy_block_allocator fpba_checker #(.ADDRESS_BITS(ADDRESS_BITS)) u_fpba_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_address (rsp_address),
   .rsp_status  (rsp_status)
);
`default_nettype wire

/* tb/fit_policy_block_allocator_test.sv */
// testbench of the fit-policy block allocator: self-checking, directed and randomised allocate/free traffic
`default_nettype none
module fit_policy_block_allocator_test;

   localparam int NBLK = fpba_pkg::MAX_BLOCKS_DEF;

   // prediction of the block table and the expected results
   class alloc_scoreboard;
      logic [1:0]  mode;
      logic [8:0]  pages;
      int unsigned bstart [NBLK];
      int unsigned bpay [NBLK];
      bit          bfree [NBLK];
      int unsigned count;
      logic [19:0] exp_addr [$];
      logic [2:0]  exp_stat [$];
      int          errors;
      int unsigned live [$];   // payload offsets of allocated blocks

      function void reform();
         int unsigned p;
         int unsigned bytes;
         p = pages;
         if (p < 1) p = 1;
         if (p > fpba_pkg::MAX_PAGES) p = fpba_pkg::MAX_PAGES;
         bytes = p << fpba_pkg::PAGE_SHIFT;
         if (bytes > (1 << 20)) bytes = 1 << 20;
         for (int i = 0; i < NBLK; i++) begin
            bstart[i] = 0; bpay[i] = 0; bfree[i] = 0;
         end
         bpay[0] = bytes - fpba_pkg::HEADER_BYTES;
         bfree[0] = 1;
         count = 1;
         live.delete();
      endfunction

      function void drop_entry(int unsigned k);
         for (int unsigned i = k; i + 1 < count; i++) begin
            bstart[i] = bstart[i+1]; bpay[i] = bpay[i+1]; bfree[i] = bfree[i+1];
         end
         count--;
      endfunction

      function void note_item(logic kind, logic [19:0] req, logic [19:0] fa);
         logic [19:0] a;
         logic [2:0]  s;
         int unsigned need, pick, i, j;
         bit found;
         a = '0;
         if (kind == fpba_pkg::KIND_ALLOC) begin
            found = 0; pick = 0;
            if (mode == fpba_pkg::MODE_NONE) s = fpba_pkg::STATUS_NO_MODE;
            else if (req == 0) s = fpba_pkg::STATUS_ZERO;
            else begin
               need = (int'(req) + 7) & ~7;
               for (i = 0; i < count; i++) begin
                  if (!bfree[i] || bpay[i] < need) continue;
                  if (!found) begin
                     pick = i; found = 1;
                     if (mode == fpba_pkg::MODE_FIRST) break;
                     continue;
                  end
                  if (mode == fpba_pkg::MODE_BEST && bpay[i] < bpay[pick]) pick = i;
                  if (mode == fpba_pkg::MODE_WORST && bpay[i] > bpay[pick]) pick = i;
               end
               if (!found) s = fpba_pkg::STATUS_NO_FIT;
               else begin
                  if (bpay[pick] - need >= fpba_pkg::HEADER_BYTES + fpba_pkg::GRAIN_BYTES
                      && count < NBLK) begin
                     for (j = count; j > pick + 1; j--) begin
                        bstart[j] = bstart[j-1]; bpay[j] = bpay[j-1]; bfree[j] = bfree[j-1];
                     end
                     bstart[pick+1] = bstart[pick] + fpba_pkg::HEADER_BYTES + need;
                     bpay[pick+1] = bpay[pick] - need - fpba_pkg::HEADER_BYTES;
                     bfree[pick+1] = 1;
                     bpay[pick] = need;
                     count++;
                  end
                  bfree[pick] = 0;
                  a = 20'(bstart[pick] + fpba_pkg::HEADER_BYTES);
                  s = fpba_pkg::STATUS_OK;
                  live.push_back(32'(a));
               end
            end
         end else begin
            s = fpba_pkg::STATUS_NOT_FOUND;
            for (i = 0; i < count; i++) begin
               if (bstart[i] + fpba_pkg::HEADER_BYTES == fa) begin
                  bfree[i] = 1;
                  s = fpba_pkg::STATUS_OK;
                  j = 0;
                  while (j + 1 < count) begin
                     if (bfree[j] && bfree[j+1]) begin
                        bpay[j] += fpba_pkg::HEADER_BYTES + bpay[j+1];
                        drop_entry(j + 1);
                     end else j++;
                  end
                  foreach (live[k]) if (live[k] == fa) begin
                     live.delete(k);
                     break;
                  end
                  break;
               end
            end
         end
         exp_addr.push_back(a);
         exp_stat.push_back(s);
      endfunction

      function void check_result(logic [19:0] a, logic [2:0] s);
         logic [19:0] ea;
         logic [2:0]  es;
         if (exp_addr.size() == 0) begin
            $display("%0t: unexpected result address %h status %0d", $time, a, s);
            errors++;
            return;
         end
         ea = exp_addr.pop_front();
         es = exp_stat.pop_front();
         if (a !== ea) begin
            $display("%0t: address expected %h actual %h", $time, ea, a);
            errors++;
         end
         if (s !== es) begin
            $display("%0t: status expected %0d actual %0d", $time, es, s);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_kind = 0;
   logic [19:0] req_request_bytes = 0;
   logic [19:0] req_free_address = 0;
   logic        rsp_valid;
   logic [19:0] rsp_address;
   logic [2:0]  rsp_status;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [2:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   alloc_scoreboard sb;
   int  idle_pct = 0;
   int  stall_cnt = 0;
   bit  finished = 0;

   always #4 clock = ~clock;

   fit_policy_block_allocator u_dut (
      .clock, .reset, .start, .busy, .req_kind, .req_request_bytes, .req_free_address,
      .rsp_valid, .rsp_address, .rsp_status, .psel, .penable, .pwrite, .paddr,
      .pwdata, .prdata, .pready
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_address, rsp_status);
   end

   // watchdog: cycles with no item and no result accepted
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt > 20000 && !finished) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_item(logic kind, logic [19:0] req, logic [19:0] fa);
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      start <= 1;
      req_kind <= kind;
      req_request_bytes <= req;
      req_free_address <= fa;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_item(kind, req, fa);
      start <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (sb.exp_addr.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] addr, logic [31:0] data);
      drain();
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (addr == 3'(4 * fpba_pkg::REG_FIT_MODE)) sb.mode = data[1:0];
      else begin
         sb.pages = data[8:0];
         sb.reform();
      end
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic random_item();
      int unsigned r;
      logic [19:0] sz;
      r = $urandom_range(99);
      if (r < 55) begin
         case ($urandom_range(3))
            0: sz = 20'($urandom_range(64));
            1: sz = 20'($urandom_range(4096));
            2: sz = 20'($urandom_range(40000));
            default: sz = 20'($urandom);
         endcase
         send_item(fpba_pkg::KIND_ALLOC, sz, 20'($urandom));
      end else if (r < 90 && sb.live.size() != 0) begin
         send_item(fpba_pkg::KIND_FREE, 20'($urandom),
                   20'(sb.live[$urandom_range(sb.live.size() - 1)]));
      end else begin
         send_item(fpba_pkg::KIND_FREE, 20'($urandom), 20'($urandom));
      end
   endtask

   initial begin
      sb = new();
      sb.mode = fpba_pkg::FIT_MODE_RESET;
      sb.pages = fpba_pkg::REGION_RESET;
      sb.reform();
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // directed part
      send_item(fpba_pkg::KIND_ALLOC, 20'd0, 20'd0);
      send_item(fpba_pkg::KIND_ALLOC, 20'd1, 20'hFFFFF);
      send_item(fpba_pkg::KIND_ALLOC, 20'hFFFFF, 20'd0);
      send_item(fpba_pkg::KIND_ALLOC, 20'd100, 20'd0);
      send_item(fpba_pkg::KIND_FREE, 20'hFFFFF, 20'd32);
      send_item(fpba_pkg::KIND_FREE, 20'd0, 20'd32);
      send_item(fpba_pkg::KIND_FREE, 20'd0, 20'hFFFFF);
      send_item(fpba_pkg::KIND_FREE, 20'd0, 20'd0);
      write_reg(3'(4 * fpba_pkg::REG_FIT_MODE), {30'h3FFFFFFF, fpba_pkg::MODE_NONE});
      send_item(fpba_pkg::KIND_ALLOC, 20'd0, 20'd0);
      send_item(fpba_pkg::KIND_ALLOC, 20'd8, 20'd0);
      write_reg(3'(4 * fpba_pkg::REG_REGION), 32'd1);
      write_reg(3'(4 * fpba_pkg::REG_FIT_MODE), 32'(fpba_pkg::MODE_FIRST));
      for (int i = 0; i < 8; i++) send_item(fpba_pkg::KIND_ALLOC, 20'd400, 20'd0);
      write_reg(3'(4 * fpba_pkg::REG_REGION), 32'hFFFFFFFF);
      write_reg(3'(4 * fpba_pkg::REG_REGION), 32'd0);
      write_reg(3'(4 * fpba_pkg::REG_REGION), 32'd256);
      // fill the table so a fit goes out whole
      for (int i = 0; i < 66; i++) send_item(fpba_pkg::KIND_ALLOC, 20'(i + 1), 20'd0);
      send_item(fpba_pkg::KIND_ALLOC, 20'hFFFFF, 20'd0);

      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: idle_pct = 0;
            1: idle_pct = 74;
            2: idle_pct = 14;
            default: idle_pct = 0;
         endcase
         write_reg(3'(4 * fpba_pkg::REG_FIT_MODE),
                   32'($urandom_range(3) == 0 ? $urandom_range(3) : $urandom_range(1, 3)));
         if (ph % 3 == 0)
            write_reg(3'(4 * fpba_pkg::REG_REGION),
                      (ph == 9) ? 32'd256 : 32'($urandom_range(1, 32)));
         for (int i = 0; i < 50; i++) random_item();
      end

      drain();
      repeat (200) @(posedge clock);
      finished = 1;
      if (sb.errors == 0 && sb.exp_addr.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/fpba_pkg.sv
rtl/fit_policy_block_allocator.sv
rtl/fpba_checker.sv
tb/fit_policy_block_allocator_test.sv
